@@ rtl/core/brt_pkg.sv @@
// Shared types and constants of the block receive tracker.
// Used by brt_front, brt_cmd_queue, brt_back and block_receive_tracker_unit.
`default_nettype none

package brt_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int MAX_LIST   = 64;

    // Field widths of the stream items.
    localparam int OP_W       = 2;
    localparam int BLK_W      = 11;
    localparam int LIMIT_W    = 7;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // The map is held as rows of WORD_W blocks each.
    localparam int ADDR_W = $clog2(MAX_BLOCKS);
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ROWS   = MAX_BLOCKS / WORD_W;
    localparam int ROW_W  = ADDR_W - BIT_W;
    localparam int CNT_W  = $clog2(MAX_LIST + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [BLK_W-1:0] BLOCK_COUNT_RST = BLK_W'(MAX_BLOCKS);

    // Configuration register indexes.
    localparam logic REG_BLOCK_COUNT = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_MARK  = 2'd0,
        OP_LIST  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_MARK  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic               mark_ok;
        logic [ADDR_W-1:0]  addr;
        logic [BLK_W-1:0]   scan_end;
        logic [CNT_W-1:0]   limit;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic               fresh;
        logic [BLK_W-1:0]   blk;
        logic               last;
        logic               all;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/brt_front.sv @@
// Front end: accepts input items, drops unused operation codes and turns each
// item into a command with range checks and clamps done. Depends on brt_pkg.
`default_nettype none

module brt_front
    import brt_pkg::*;
(
    input  wire logic                 i_valid,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic [BLK_W-1:0]     i_live,
    input  wire logic                 i_q_full,
    output logic                      o_ready,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    logic [BLK_W-1:0]   w_seq;
    logic [BLK_W-1:0]   w_end;
    logic [LIMIT_W-1:0] w_lim;
    logic [BLK_W-1:0]   w_seq_m1;
    logic               w_known;

    assign w_seq    = i_data[BLK_W-1:0];
    assign w_end    = i_data[2*BLK_W-1:BLK_W];
    assign w_lim    = i_data[2*BLK_W+LIMIT_W-1:2*BLK_W];
    assign w_seq_m1 = w_seq - BLK_W'(1);

    // Operation code three is taken and dropped without a result.
    assign w_known = (i_op == OP_MARK) || (i_op == OP_LIST) || (i_op == OP_CLEAR);
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && w_known;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = t_op'(i_op);
        o_cmd.mark_ok = (w_seq != '0) && (w_seq <= i_live);
        o_cmd.addr    = w_seq_m1[ADDR_W-1:0];
        o_cmd.scan_end = (w_end > i_live) ? i_live : w_end;
        if (w_lim == '0) begin
            o_cmd.limit = CNT_W'(1);
        end else if (w_lim > LIMIT_W'(MAX_LIST)) begin
            o_cmd.limit = CNT_W'(MAX_LIST);
        end else begin
            o_cmd.limit = CNT_W'(w_lim);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/brt_cmd_queue.sv @@
// Short command queue between front end and execution engine.
// Depends on brt_pkg for the command type and the depth.
`default_nettype none

module brt_cmd_queue
    import brt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_q[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/brt_back.sv @@
// Execution engine: holds the received map as rows in a memory with a valid
// bit per row, runs marks, clears and missing-block scans, drives the result
// register. Depends on brt_pkg.
`default_nettype none

module brt_back
    import brt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [BLK_W-1:0] i_live,
    input  wire logic             i_clear,
    input  wire logic             i_q_valid,
    input  t_cmd                  i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    output t_result               o_out,
    input  wire logic             i_out_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_SCAN_RD,
        S_SCAN_LD,
        S_SCAN_EMIT,
        S_FLUSH
    } t_state;

    logic [WORD_W-1:0] mem [ROWS];

    t_state            r_state,      n_state;
    t_cmd              r_cmd,        n_cmd;
    logic [ROW_W-1:0]  r_row,        n_row;
    logic [WORD_W-1:0] r_miss,       n_miss;
    logic [CNT_W-1:0]  r_found,      n_found;
    logic              r_pend_valid, n_pend_valid;
    logic [BLK_W-1:0]  r_pend_blk,   n_pend_blk;
    logic [BLK_W-1:0]  r_total,      n_total;
    logic [ROWS-1:0]   r_row_valid,  n_row_valid;
    logic              r_out_valid,  n_out_valid;
    t_result           r_out,        n_out;
    logic [WORD_W-1:0] r_rd_data;

    logic              w_out_free;
    logic              w_rd_en;
    logic [ROW_W-1:0]  w_rd_addr;
    logic              w_wr_en;
    logic [ROW_W-1:0]  w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;

    logic [ROW_W-1:0]  w_mrow;
    logic [BIT_W-1:0]  w_mbit;
    logic [WORD_W-1:0] w_mword;
    logic              w_mfresh;
    logic [WORD_W-1:0] w_sword;
    logic [WORD_W-1:0] w_range;
    logic [BIT_W-1:0]  w_pos;
    logic [BLK_W-1:0]  w_found_blk;
    logic [BLK_W-1:0]  w_row_end;
    logic              w_last_row;

    logic              w_emit;
    t_kind             w_e_kind;
    logic              w_e_fresh;
    logic [BLK_W-1:0]  w_e_blk;
    logic              w_e_last;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A row never written since the last clear reads as all not received.
    assign w_mrow   = r_cmd.addr[ADDR_W-1:BIT_W];
    assign w_mbit   = r_cmd.addr[BIT_W-1:0];
    assign w_mword  = r_row_valid[w_mrow] ? r_rd_data : '0;
    assign w_mfresh = r_cmd.mark_ok && !w_mword[w_mbit];
    assign w_sword  = r_row_valid[r_row] ? r_rd_data : '0;

    always_comb begin
        for (int k = 0; k < WORD_W; k++) begin
            w_range[k] = ({1'b0, r_row, BIT_W'(k)} < r_cmd.scan_end);
        end
    end

    always_comb begin
        w_pos = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (r_miss[k]) begin
                w_pos = BIT_W'(k);
            end
        end
    end

    assign w_found_blk = {1'b0, r_row, w_pos} + BLK_W'(1);
    assign w_row_end   = {1'b0, r_row, {BIT_W{1'b0}}} + BLK_W'(WORD_W);
    assign w_last_row  = (w_row_end >= r_cmd.scan_end);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_row        = r_row;
        n_miss       = r_miss;
        n_found      = r_found;
        n_pend_valid = r_pend_valid;
        n_pend_blk   = r_pend_blk;
        n_total      = r_total;
        n_row_valid  = r_row_valid;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_row;
        w_wr_en      = 1'b0;
        w_wr_addr    = w_mrow;
        w_wr_data    = w_mword | (WORD_W'(1) << w_mbit);
        w_emit       = 1'b0;
        w_e_kind     = KIND_MARK;
        w_e_fresh    = 1'b0;
        w_e_blk      = '0;
        w_e_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_MARK: begin
                            o_q_pop   = 1'b1;
                            n_cmd     = i_q_cmd;
                            w_rd_en   = 1'b1;
                            w_rd_addr = i_q_cmd.addr[ADDR_W-1:BIT_W];
                            n_state   = S_MARK;
                        end
                        OP_LIST: begin
                            o_q_pop      = 1'b1;
                            n_cmd        = i_q_cmd;
                            n_row        = '0;
                            n_found      = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_SCAN_RD;
                        end
                        OP_CLEAR: begin
                            if (w_out_free) begin
                                o_q_pop     = 1'b1;
                                n_total     = '0;
                                n_row_valid = '0;
                                w_emit      = 1'b1;
                                w_e_kind    = KIND_CLEAR;
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_MARK: begin
                if (w_out_free) begin
                    if (w_mfresh) begin
                        w_wr_en             = 1'b1;
                        n_row_valid[w_mrow] = 1'b1;
                        n_total             = r_total + BLK_W'(1);
                    end
                    w_emit    = 1'b1;
                    w_e_kind  = KIND_MARK;
                    w_e_fresh = w_mfresh;
                    n_state   = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                w_rd_en = 1'b1;
                n_state = S_SCAN_LD;
            end
            S_SCAN_LD: begin
                n_miss  = ~w_sword & w_range;
                n_state = S_SCAN_EMIT;
            end
            S_SCAN_EMIT: begin
                if (r_miss != '0) begin
                    // The newest find is held back until the next one shows
                    // whether it ends the list.
                    if (!r_pend_valid || w_out_free) begin
                        if (r_pend_valid) begin
                            w_emit   = 1'b1;
                            w_e_kind = KIND_ENTRY;
                            w_e_blk  = r_pend_blk;
                            w_e_last = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_blk   = w_found_blk;
                        n_found      = r_found + CNT_W'(1);
                        n_miss       = r_miss & ~(WORD_W'(1) << w_pos);
                        if (r_found + CNT_W'(1) == r_cmd.limit) begin
                            n_state = S_FLUSH;
                        end
                    end
                end else if (w_last_row) begin
                    n_state = S_FLUSH;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_pend_valid) begin
                        w_e_kind = KIND_ENTRY;
                        w_e_blk  = r_pend_blk;
                    end else begin
                        w_e_kind = KIND_NONE;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_clear) begin
            n_total     = '0;
            n_row_valid = '0;
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out.kind  = w_e_kind;
            n_out.fresh = w_e_fresh;
            n_out.blk   = w_e_blk;
            n_out.last  = w_e_last;
            n_out.all   = (n_total >= i_live);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_total      <= '0;
            r_row_valid  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_total      <= n_total;
            r_row_valid  <= n_row_valid;
            r_out_valid  <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_row      <= n_row;
        r_miss     <= n_miss;
        r_found    <= n_found;
        r_pend_blk <= n_pend_blk;
        r_out      <= n_out;
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= BLK_W'(MAX_BLOCKS))
        else $error("received total exceeds map size");

    a_found_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_EMIT) |-> (r_found < r_cmd.limit))
        else $error("scan continued past its list limit");

    a_clear_empties_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_total == '0 && r_row_valid == '0))
        else $error("map not emptied after a count write");

    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_ENTRY) |-> (r_out.blk != '0))
        else $error("missing entry reports block zero");

endmodule

`default_nettype wire

@@ rtl/core/block_receive_tracker_unit.sv @@
// Block receive tracker top level: stream ports, the block count register
// and the front end, command queue and engine. Depends on brt_pkg.
//
// Usage: each item on the s_axis side carries an operation in s_axis_tuser:
// mark a block received, list missing blocks, or clear the map. Results leave
// on the m_axis side, one per mark or clear and one or more per list, with
// m_axis_tlast on the final result of an item. Operation code three is taken
// and produces nothing.
// A mark passes the queue, a memory read and the result register, a clear
// the queue and the result register. A list walks the map one 32-block row
// at a time, reading each row and picking out its missing entries; a full
// 1024-block scan gives up to 64 entries. The engine handles one item at
// a time; a two-entry command queue takes up to two more items meanwhile.
// Reset: block_count returns to 1024, the map is empty, no result is pending.
// Writing block_count over the APB port also empties the map.
// When the m_axis side stalls, the result register holds, the engine waits,
// and once the queue is full s_axis_tready drops.
`default_nettype none

module block_receive_tracker_unit
    import brt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, lowest bit up: seq_number[10:0], scan_end[21:11],
    // list_limit[28:22], zero padding
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op
    input  wire logic [OP_W-1:0]       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, lowest bit up: newly_received[0], missing_block[11:1],
    // all_received[12], zero padding
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: result_kind
    output logic [KIND_W-1:0]          m_axis_tuser,
    output logic                       m_axis_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [BLK_W-1:0] r_block_count;
    logic [BLK_W-1:0] w_live;
    logic             w_cfg_wr;

    logic    w_q_full;
    logic    w_push;
    t_cmd    w_push_cmd;
    logic    w_q_valid;
    t_cmd    w_q_cmd;
    logic    w_q_pop;
    t_result w_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);
    assign prdata   = (paddr[2] == REG_BLOCK_COUNT) ? {{(32 - BLK_W){1'b0}}, r_block_count}
                                                    : '0;
    assign w_live   = (r_block_count > BLK_W'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS)
                                                           : r_block_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
        end else if (w_cfg_wr) begin
            r_block_count <= pwdata[BLK_W-1:0];
        end
    end

    brt_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .i_live   (w_live),
        .i_q_full (w_q_full),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    brt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    brt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_live      (w_live),
        .i_clear     (w_cfg_wr),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .o_out       (w_out),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last;
    assign m_axis_tdata = {{(OUT_DATA_W - BLK_W - 2){1'b0}}, w_out.all, w_out.blk,
                           w_out.fresh};

endmodule

`default_nettype wire
